FILE: src/dlle_pkg.sv
// dlle_pkg: shared constants and types for the DNS label length encoder.
// Used by every module of the block and by the channel interfaces.
// No dependencies.
package dlle_pkg;

  localparam int MAX_LABEL = 63;
  localparam int CNT_W     = $clog2(MAX_LABEL + 1);
  localparam int ADDR_W    = CNT_W + 1;             // bank bit + character index
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'd46;
  localparam logic [CNT_W-1:0]  LABEL_MAX = CNT_W'(MAX_LABEL);

  // One finished label waiting to be sent.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic             last;
  } label_cmd_t;

  // Character store write port, front to back.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

FILE: src/dlle_if.sv
// dlle_if: valid/ready channel interfaces for the character input and byte output.
// Depends on dlle_pkg for the byte width.
interface dlle_in_if;
  logic                      valid;
  logic                      ready;
  logic [dlle_pkg::BYTE_W-1:0] name_char;
  logic                      is_final;

  modport source (output valid, output name_char, output is_final, input ready);
  modport sink   (input valid, input name_char, input is_final, output ready);
endinterface

interface dlle_out_if;
  logic                      valid;
  logic                      ready;
  logic [dlle_pkg::BYTE_W-1:0] out_byte;
  logic                      run_end;
  logic                      name_end;
  logic                      label_too_long;

  modport source (output valid, output out_byte, output run_end, output name_end,
                  output label_too_long, input ready);
  modport sink   (input valid, input out_byte, input run_end, input name_end,
                  input label_too_long, output ready);
endinterface

FILE: src/dns_label_length_encoder.sv
// dns_label_length_encoder: top level; dotted name in, DNS wire labels out.
// Depends on dlle_pkg, dlle_if, dlle_front, dlle_cmd_fifo, dlle_back.
//
//   channel   dir   payload                                      handshake
//   in_ch     in    name_char[7:0], is_final                     valid/ready
//   out_ch    out   out_byte[7:0], run_end, name_end,            valid/ready
//                   label_too_long
//
// A label of n stored characters leaves as n+1 bytes at one byte per cycle
// while out_ch is not stalled, the rate of the single store read port.
// The store has two banks, so one label can be filled while the previous one
// drains; input stalls only when both banks hold unsent labels.
// The output register holds its byte while out_ch.ready is low.
// Synchronous active-low reset; the first item can be taken right after it.
module dns_label_length_encoder (
  input  logic        clk,
  input  logic        rst_n,
  dlle_in_if.sink     in_ch,
  dlle_out_if.source  out_ch
);

  dlle_pkg::label_cmd_t push_cmd, head;
  dlle_pkg::store_wr_t  st_wr;
  logic                 push, pop, q_empty, q_full;

  dlle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cmd  (push_cmd),
    .st_wr  (st_wr)
  );

  dlle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  dlle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .st_wr   (st_wr),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: src/dlle_front.sv
// dlle_front: accepts characters, fills the current store bank and queues a
// label command on a dot or the final character. Depends on dlle_pkg, dlle_if.
module dlle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  dlle_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output dlle_pkg::label_cmd_t q_cmd,
  output dlle_pkg::store_wr_t  st_wr
);

  logic                       bank_r, bank_nxt;
  logic [dlle_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       acc, is_dot, room;
  logic [dlle_pkg::CNT_W-1:0] cnt_after;
  logic                       ovf_after;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign is_dot      = (in_ch.name_char == dlle_pkg::DOT_CHAR);
  assign room        = (cnt_r < dlle_pkg::LABEL_MAX);

  always_comb begin
    cnt_after = (room && !is_dot) ? cnt_r + dlle_pkg::CNT_W'(1) : cnt_r;
    ovf_after = ovf_r | (!room && !is_dot);

    st_wr.en   = acc && !is_dot && room;
    st_wr.addr = {bank_r, cnt_r};
    st_wr.data = in_ch.name_char;

    q_push        = acc && (is_dot || in_ch.is_final);
    q_cmd.bank    = bank_r;
    q_cmd.cnt     = cnt_after;
    q_cmd.ovf     = ovf_after;
    q_cmd.last    = in_ch.is_final;

    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (q_push) begin
      // label handed over; next one goes to the other bank
      bank_nxt = !bank_r;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (acc) begin
      cnt_nxt = cnt_after;
      ovf_nxt = ovf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

FILE: src/dlle_cmd_fifo.sv
// dlle_cmd_fifo: two-entry queue of label commands between front and back.
// Depends on dlle_pkg.
module dlle_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dlle_pkg::label_cmd_t push_cmd,
  input  logic                 pop,
  output dlle_pkg::label_cmd_t head,
  output logic                 empty,
  output logic                 full
);

  dlle_pkg::label_cmd_t ent_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;

  assign head  = ent_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/dlle_back.sv
// dlle_back: two-bank character store and the sequencer that sends each queued
// label as a length byte and its characters. Depends on dlle_pkg, dlle_if.
module dlle_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dlle_pkg::store_wr_t  st_wr,
  input  dlle_pkg::label_cmd_t head,
  input  logic                 q_empty,
  output logic                 q_pop,
  dlle_out_if.source           out_ch
);

  typedef enum logic {
    ST_LEN,
    ST_CHARS
  } state_t;

  logic [dlle_pkg::BYTE_W-1:0] store_mem [2**dlle_pkg::ADDR_W];
  logic [dlle_pkg::BYTE_W-1:0] rd_q_r;

  state_t                      state_r, state_nxt;
  logic [dlle_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                        valid_r, valid_nxt;
  logic [dlle_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                        run_end_r, run_end_nxt;
  logic                        name_end_r, name_end_nxt;
  logic                        too_long_r, too_long_nxt;
  logic                        slot_free, idx_last;

  assign slot_free = !valid_r || out_ch.ready;
  assign idx_last  = (idx_r == head.cnt - dlle_pkg::CNT_W'(1));

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    valid_nxt    = out_ch.ready ? 1'b0 : valid_r;
    byte_nxt     = byte_r;
    run_end_nxt  = run_end_r;
    name_end_nxt = name_end_r;
    too_long_nxt = too_long_r;
    q_pop        = 1'b0;
    unique case (state_r)
      ST_LEN: begin
        idx_nxt = '0;
        if (!q_empty && slot_free) begin
          valid_nxt    = 1'b1;
          byte_nxt     = dlle_pkg::BYTE_W'(head.cnt);
          run_end_nxt  = (head.cnt == '0);
          name_end_nxt = (head.cnt == '0) && head.last;
          too_long_nxt = head.ovf;
          if (head.cnt == '0) q_pop = 1'b1;
          else                state_nxt = ST_CHARS;
        end
      end
      ST_CHARS: begin
        if (slot_free) begin
          valid_nxt    = 1'b1;
          byte_nxt     = rd_q_r;
          run_end_nxt  = idx_last;
          name_end_nxt = idx_last && head.last;
          too_long_nxt = head.ovf;
          if (idx_last) begin
            q_pop     = 1'b1;
            state_nxt = ST_LEN;
          end else begin
            idx_nxt = idx_r + dlle_pkg::CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_LEN;
    endcase
  end

  // read data always follows the character index of the next cycle
  always_ff @(posedge clk) begin
    if (st_wr.en) store_mem[st_wr.addr] <= st_wr.data;
    rd_q_r <= store_mem[{head.bank, idx_nxt}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LEN;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    byte_r     <= byte_nxt;
    run_end_r  <= run_end_nxt;
    name_end_r <= name_end_nxt;
    too_long_r <= too_long_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.out_byte       = byte_r;
  assign out_ch.run_end        = run_end_r;
  assign out_ch.name_end       = name_end_r;
  assign out_ch.label_too_long = too_long_r;

endmodule
